@@ hdl/ragdd_pkg.sv @@
`default_nettype none

package ragdd_pkg;

    localparam int DEF_NUM_LOCKS = 8;
    localparam int DEF_NUM_PROCS = 8;
    localparam int MAX_RESULTS   = 16;
    localparam int ECNT_W        = $clog2(MAX_RESULTS);
    localparam int NODE_W        = 4;
    localparam int ACTION_W      = 2;
    localparam int ID_W          = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REQUEST = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_DEALLOC = 2'd2,
        ACT_DETECT  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD_LOCK,
        ST_UPD_PROC,
        ST_ACK,
        ST_INIT,
        ST_SEARCH,
        ST_POP,
        ST_EMIT_ORIGIN,
        ST_EMIT_PATH,
        ST_EMIT_POP,
        ST_NONE
    } state_t;

    typedef enum logic [1:0] {
        OUT_ACK,
        OUT_ORIGIN,
        OUT_PATH
    } out_sel_t;

    typedef enum logic [1:0] {
        STEP_FOUND,
        STEP_PUSH,
        STEP_POP,
        STEP_EXHAUSTED
    } outcome_t;

    typedef struct packed {
        logic     capture;
        logic     upd_lock;
        logic     upd_proc;
        logic     init_origin;
        logic     next_origin;
        logic     step;
        logic     pop;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        outcome_t outcome;
        logic     origin_last;
        logic     sp_zero;
        logic     path_last;
        logic     out_free;
    } status_t;

endpackage

`default_nettype wire

@@ hdl/rag_deadlock_detector_core.sv @@
// edge update: UPD_LOCK, then UPD_PROC, then ACK registers the acknowledge
// detect: per origin an INIT step, a SEARCH step per node entered and POP then
//   SEARCH per backtrack, over up to N origins; EMIT_POP between path results
// throughput: one item at a time, next item taken once the last result is registered
// reset: asynchronous, clears the graph, search state and the result valid flag
`default_nettype none

module rag_deadlock_detector_core
#(
    parameter int NUM_LOCKS = ragdd_pkg::DEF_NUM_LOCKS,
    parameter int NUM_PROCS = ragdd_pkg::DEF_NUM_PROCS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ragdd_pkg::ACTION_W-1:0]    action,
    input  wire logic [ragdd_pkg::ID_W-1:0]        proc_id,
    input  wire logic [ragdd_pkg::ID_W-1:0]        lock_num,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   deadlock,
    output logic [ragdd_pkg::NODE_W-1:0]           node,
    output logic                                   last
);

    ragdd_pkg::cmd_t    cmd;
    ragdd_pkg::status_t status;

    ragdd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ragdd_datapath
    #(
        .NUM_LOCKS (NUM_LOCKS),
        .NUM_PROCS (NUM_PROCS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .proc_id   (proc_id),
        .lock_num  (lock_num),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .deadlock  (deadlock),
        .node      (node),
        .last      (last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item taken while previous item still in work");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten while held");

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.upd_lock, cmd.upd_proc, cmd.init_origin,
                  cmd.step, cmd.pop}))
        else $error("conflicting datapath commands");

    a_no_cycle_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !deadlock) |-> last)
        else $error("acknowledge or no-cycle result not marked last");

endmodule

`default_nettype wire

@@ hdl/ragdd_ctrl.sv @@
`default_nettype none

module ragdd_ctrl
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic [ragdd_pkg::ACTION_W-1:0]    action,
    output logic                                   in_stall,
    input  wire ragdd_pkg::status_t                status,
    output ragdd_pkg::cmd_t                        cmd
);

    ragdd_pkg::state_t state_reg;
    ragdd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ragdd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_sel = ragdd_pkg::OUT_ACK;
        in_stall    = 1'b1;
        unique case (state_reg)
            ragdd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (action == ragdd_pkg::ACT_DETECT)
                    begin
                        state_next = ragdd_pkg::ST_INIT;
                    end
                    else
                    begin
                        state_next = ragdd_pkg::ST_UPD_LOCK;
                    end
                end
            end
            ragdd_pkg::ST_UPD_LOCK:
            begin
                cmd.upd_lock = 1'b1;
                state_next   = ragdd_pkg::ST_UPD_PROC;
            end
            ragdd_pkg::ST_UPD_PROC:
            begin
                cmd.upd_proc = 1'b1;
                state_next   = ragdd_pkg::ST_ACK;
            end
            ragdd_pkg::ST_ACK,
            ragdd_pkg::ST_NONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = ragdd_pkg::OUT_ACK;
                    state_next   = ragdd_pkg::ST_IDLE;
                end
            end
            ragdd_pkg::ST_INIT:
            begin
                cmd.init_origin = 1'b1;
                state_next      = ragdd_pkg::ST_SEARCH;
            end
            ragdd_pkg::ST_SEARCH:
            begin
                cmd.step = 1'b1;
                unique case (status.outcome)
                    ragdd_pkg::STEP_FOUND:     state_next = ragdd_pkg::ST_EMIT_ORIGIN;
                    ragdd_pkg::STEP_PUSH:      state_next = ragdd_pkg::ST_SEARCH;
                    ragdd_pkg::STEP_POP:       state_next = ragdd_pkg::ST_POP;
                    ragdd_pkg::STEP_EXHAUSTED:
                    begin
                        if (status.origin_last)
                        begin
                            state_next = ragdd_pkg::ST_NONE;
                        end
                        else
                        begin
                            cmd.next_origin = 1'b1;
                            state_next      = ragdd_pkg::ST_INIT;
                        end
                    end
                    default:                   state_next = ragdd_pkg::ST_IDLE;
                endcase
            end
            ragdd_pkg::ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ragdd_pkg::ST_SEARCH;
            end
            ragdd_pkg::ST_EMIT_ORIGIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = ragdd_pkg::OUT_ORIGIN;
                    state_next   = status.sp_zero ? ragdd_pkg::ST_IDLE
                                                  : ragdd_pkg::ST_EMIT_PATH;
                end
            end
            ragdd_pkg::ST_EMIT_PATH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = ragdd_pkg::OUT_PATH;
                    state_next   = status.path_last ? ragdd_pkg::ST_IDLE
                                                    : ragdd_pkg::ST_EMIT_POP;
                end
            end
            ragdd_pkg::ST_EMIT_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ragdd_pkg::ST_EMIT_PATH;
            end
            default:
            begin
                state_next = ragdd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/ragdd_datapath.sv @@
`default_nettype none

module ragdd_datapath
#(
    parameter int NUM_LOCKS = ragdd_pkg::DEF_NUM_LOCKS,
    parameter int NUM_PROCS = ragdd_pkg::DEF_NUM_PROCS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [ragdd_pkg::ACTION_W-1:0]    action,
    input  wire logic [ragdd_pkg::ID_W-1:0]        proc_id,
    input  wire logic [ragdd_pkg::ID_W-1:0]        lock_num,
    input  wire logic                              out_stall,
    input  wire ragdd_pkg::cmd_t                   cmd,
    output ragdd_pkg::status_t                     status,
    output logic                                   out_valid,
    output logic                                   deadlock,
    output logic [ragdd_pkg::NODE_W-1:0]           node,
    output logic                                   last
);

    localparam int N  = NUM_LOCKS + NUM_PROCS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    typedef struct packed {
        logic [IW-1:0] nd;
        logic [CW-1:0] idx;
    } frame_t;

    // item registers
    ragdd_pkg::action_t             act_reg;
    logic [ragdd_pkg::ID_W-1:0]     pid_reg;
    logic [ragdd_pkg::ID_W-1:0]     lk_reg;

    // graph and search state
    logic [N-1:0]                   adj_reg [N];
    logic [N-1:0]                   visited_reg;
    logic [IW-1:0]                  origin_reg;
    logic [IW-1:0]                  cur_reg;
    logic [CW-1:0]                  idx_reg;
    logic [IW-1:0]                  sp_reg;
    frame_t                         stk_mem [N];
    frame_t                         rd_q;
    logic [ragdd_pkg::ECNT_W-1:0]   ecnt_reg;

    // result register
    logic                           out_valid_reg;
    logic                           deadlock_reg;
    logic [ragdd_pkg::NODE_W-1:0]   node_reg;
    logic                           last_reg;

    logic                           ids_ok;
    logic [IW-1:0]                  lk_node;
    logic [IW-1:0]                  pn_node;
    logic [N-1:0]                   row;
    logic [N-1:0]                   cand;
    logic                           any_cand;
    logic [IW-1:0]                  sel;
    ragdd_pkg::outcome_t            outcome;
    logic                           do_push;
    logic [IW-1:0]                  rd_addr;
    logic                           out_free;
    logic                           path_last;

    assign ids_ok  = (32'(pid_reg) < NUM_PROCS) && (32'(lk_reg) < NUM_LOCKS);
    assign lk_node = IW'(lk_reg);
    assign pn_node = IW'(32'(NUM_LOCKS) + 32'(pid_reg));

    // candidates from the current row: at or past the resume index, and
    // either the origin itself or not yet visited
    assign row = adj_reg[cur_reg];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            cand[i] = row[i] && (CW'(i) >= idx_reg)
                      && ((IW'(i) == origin_reg) || !visited_reg[i]);
        end
    end

    // lowest candidate wins
    always_comb
    begin
        sel      = '0;
        any_cand = 1'b0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                sel      = IW'(i);
                any_cand = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!any_cand)
        begin
            outcome = (sp_reg == '0) ? ragdd_pkg::STEP_EXHAUSTED : ragdd_pkg::STEP_POP;
        end
        else if (sel == origin_reg)
        begin
            outcome = ragdd_pkg::STEP_FOUND;
        end
        else
        begin
            outcome = ragdd_pkg::STEP_PUSH;
        end
    end

    assign do_push   = cmd.step && (outcome == ragdd_pkg::STEP_PUSH);
    assign rd_addr   = sp_reg - 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign path_last = (sp_reg == IW'(1))
                       || (ecnt_reg == ragdd_pkg::ECNT_W'(ragdd_pkg::MAX_RESULTS - 1));

    assign status.outcome     = outcome;
    assign status.origin_last = (origin_reg == IW'(N - 1));
    assign status.sp_zero     = (sp_reg == '0);
    assign status.path_last   = path_last;
    assign status.out_free    = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= ragdd_pkg::action_t'(action);
            pid_reg <= proc_id;
            lk_reg  <= lock_num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < N; r++)
            begin
                adj_reg[r] <= '0;
            end
        end
        else if (ids_ok)
        begin
            if (cmd.upd_lock && ((act_reg == ragdd_pkg::ACT_ALLOC)
                                 || (act_reg == ragdd_pkg::ACT_DEALLOC)))
            begin
                adj_reg[lk_node][pn_node] <= (act_reg == ragdd_pkg::ACT_ALLOC);
            end
            if (cmd.upd_proc)
            begin
                adj_reg[pn_node][lk_node] <= (act_reg == ragdd_pkg::ACT_REQUEST);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            origin_reg  <= '0;
            cur_reg     <= '0;
            idx_reg     <= '0;
            sp_reg      <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                origin_reg <= '0;
            end
            else if (cmd.next_origin)
            begin
                origin_reg <= origin_reg + 1'b1;
            end

            if (cmd.init_origin)
            begin
                visited_reg <= N'(1) << origin_reg;
                cur_reg     <= origin_reg;
                idx_reg     <= '0;
                sp_reg      <= '0;
            end
            else if (do_push)
            begin
                visited_reg[sel] <= 1'b1;
                cur_reg          <= sel;
                idx_reg          <= '0;
                sp_reg           <= sp_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                cur_reg <= rd_q.nd;
                idx_reg <= rd_q.idx;
                sp_reg  <= sp_reg - 1'b1;
            end
        end
    end

    // frame stack: parent node and where its scan resumes
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stk_mem[sp_reg] <= '{nd: cur_reg, idx: CW'(sel) + 1'b1};
        end
        rd_q <= stk_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ecnt_reg      <= '0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.out_load && (cmd.out_sel == ragdd_pkg::OUT_ORIGIN))
            begin
                ecnt_reg <= ragdd_pkg::ECNT_W'(1);
            end
            else if (cmd.out_load && (cmd.out_sel == ragdd_pkg::OUT_PATH))
            begin
                ecnt_reg <= ecnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                ragdd_pkg::OUT_ORIGIN:
                begin
                    deadlock_reg <= 1'b1;
                    node_reg     <= ragdd_pkg::NODE_W'(origin_reg);
                    last_reg     <= (sp_reg == '0);
                end
                ragdd_pkg::OUT_PATH:
                begin
                    deadlock_reg <= 1'b1;
                    node_reg     <= ragdd_pkg::NODE_W'(cur_reg);
                    last_reg     <= path_last;
                end
                default:
                begin
                    deadlock_reg <= 1'b0;
                    node_reg     <= '0;
                    last_reg     <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign deadlock  = deadlock_reg;
    assign node      = node_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
